@@ rtl/idt_pkg.sv @@
// shared types and constants for the integer to decimal text converter
`timescale 1ns / 1ps

package idt_pkg;

    // width of one packed decimal digit
    localparam int DIGIT_W = 4;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // shift-add-3 correction
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIZE = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

@@ rtl/idt_if.sv @@
// request channel interfaces for the integer input and the character output
`timescale 1ns / 1ps

interface idt_in_if #(
    parameter int W = 64
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface idt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ rtl/idt_dabble_step.sv @@
// one shift-add-3 step of the binary to packed decimal conversion
`timescale 1ns / 1ps

module idt_dabble_step #(
    parameter int NDIG = 20
) (
    input  logic [NDIG*idt_pkg::DIGIT_W-1:0] i_bcd,
    input  logic                             i_bit,
    output logic [NDIG*idt_pkg::DIGIT_W-1:0] o_bcd
);
    import idt_pkg::*;

    logic [NDIG*DIGIT_W-1:0] w_adj;

    // add 3 to every digit of five or more, digits are independent
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (i_bcd[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
                w_adj[i*DIGIT_W +: DIGIT_W] = i_bcd[i*DIGIT_W +: DIGIT_W] + BCD_ADJ;
            end else begin
                w_adj[i*DIGIT_W +: DIGIT_W] = i_bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // shift in the next binary bit
    assign o_bcd = {w_adj[NDIG*DIGIT_W-2:0], i_bit};

endmodule

@@ rtl/idt_lead_enc.sv @@
// finds the number of significant decimal digits, at least one
`timescale 1ns / 1ps

module idt_lead_enc #(
    parameter int NDIG  = 20,
    parameter int CNT_W = 5
) (
    input  logic [NDIG*idt_pkg::DIGIT_W-1:0] i_bcd,
    output logic [CNT_W-1:0]                 o_count
);
    import idt_pkg::*;

    // highest non-zero digit wins, zero keeps a single digit
    always_comb begin
        o_count = CNT_W'(1);
        for (int i = 0; i < NDIG; i++) begin
            if (i_bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
                o_count = CNT_W'(i + 1);
            end
        end
    end

endmodule

@@ rtl/integer_to_decimal_text_top.sv @@
// top level: signed integer to decimal ascii text, one character per output transfer
//
//  channel  dir  payload               handshake
//  i_in     in   value[INT_WIDTH-1:0]  valid/ready
//  o_out    out  char_code[7:0], last  valid/ready
//
// an item is converted bit by bit in the shared shift-add-3 unit, then sized, then
// sent at one character per cycle while the output does not stall (up to MAX_CHARS).
// the converter takes no new request until the last character is registered.
// reset (i_rst_n low, synchronous) returns the sequencer to idle and empties
// the output register. a stalled output holds its character and pauses emission.
`timescale 1ns / 1ps

module integer_to_decimal_text_top #(
    parameter int INT_WIDTH = 64,
    parameter int MAX_CHARS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idt_in_if.sink     i_in,
    idt_out_if.source  o_out
);
    import idt_pkg::*;

    // decimal digits needed for any INT_WIDTH-bit magnitude
    localparam int NDIG    = (INT_WIDTH * 30103) / 100000 + 1;
    localparam int CNT_W   = $clog2(NDIG + 1);
    localparam int IDX_W   = $clog2(NDIG);
    localparam int TOT_MAX = (NDIG + 1 > MAX_CHARS) ? NDIG + 1 : MAX_CHARS;
    localparam int CHR_W   = $clog2(TOT_MAX + 1);
    localparam int STEP_W  = $clog2(INT_WIDTH);
    localparam int BCD_W   = NDIG * DIGIT_W;

    t_state                r_state, n_state;
    logic [INT_WIDTH-1:0]  r_shift, n_shift;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [IDX_W-1:0]      r_ptr, n_ptr;
    logic [CHR_W-1:0]      r_left, n_left;
    logic                  r_sign_pend, n_sign_pend;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic                  w_accept;
    logic                  w_in_neg;
    logic [INT_WIDTH-1:0]  w_in_raw;
    logic [INT_WIDTH-1:0]  w_in_mag;
    logic [BCD_W-1:0]      w_step_bcd;
    logic [CNT_W-1:0]      w_count;
    logic [CHR_W-1:0]      w_total;
    logic                  w_load;
    logic [DIGIT_W-1:0]    w_digit;

    // input side: magnitude as an unsigned value
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_in_raw   = i_in.value[INT_WIDTH-1:0];
    assign w_in_neg   = w_in_raw[INT_WIDTH-1];
    assign w_in_mag   = w_in_neg ? (~w_in_raw + INT_WIDTH'(1)) : w_in_raw;

    // shared shift-add-3 unit
    idt_dabble_step #(.NDIG(NDIG)) u_step (
        .i_bcd (r_bcd),
        .i_bit (r_shift[INT_WIDTH-1]),
        .o_bcd (w_step_bcd)
    );

    // significant digit count
    idt_lead_enc #(.NDIG(NDIG), .CNT_W(CNT_W)) u_lead (
        .i_bcd   (r_bcd),
        .o_count (w_count)
    );

    // characters to send, clipped to the text limit
    always_comb begin
        w_total = CHR_W'(w_count) + CHR_W'(r_neg);
        if (w_total > CHR_W'(MAX_CHARS)) begin
            w_total = CHR_W'(MAX_CHARS);
        end
    end

    assign w_digit = r_bcd[{r_ptr, 2'b00} +: DIGIT_W];
    assign w_load  = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_step      = r_step;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_sign_pend = r_sign_pend;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_shift = w_in_mag;
                    n_neg   = w_in_neg;
                    n_bcd   = '0;
                    n_step  = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd   = w_step_bcd;
                n_shift = {r_shift[INT_WIDTH-2:0], 1'b0};
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(INT_WIDTH - 1)) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                n_ptr       = IDX_W'(w_count - CNT_W'(1));
                n_left      = w_total;
                n_sign_pend = r_neg;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = (r_left == CHR_W'(1));
                    n_left      = r_left - CHR_W'(1);
                    if (r_sign_pend) begin
                        n_out_char  = CHAR_MINUS;
                        n_sign_pend = 1'b0;
                    end else begin
                        n_out_char = CHAR_ZERO + {4'd0, w_digit};
                        n_ptr      = r_ptr - IDX_W'(1);
                    end
                    if (r_left == CHR_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_bcd       <= n_bcd;
        r_neg       <= n_neg;
        r_step      <= n_step;
        r_ptr       <= n_ptr;
        r_left      <= n_left;
        r_sign_pend <= n_sign_pend;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
    end

    // output register drives the channel
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.is_last   = r_out_last;

endmodule

@@ bench/tb_integer_to_decimal_text_top.sv @@
// testbench: integer to decimal text converter checked against a predicted character stream
`timescale 1ns / 1ps

import idt_pkg::*;

// one predicted output character
typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
} t_text_char;

// holds the characters still owed by the block and compares arrivals in order
class decimal_text_checker;
    t_text_char pending_chars[$];
    int         errors;
    int         chars_seen;
    int         values_noted;

    function new();
        errors       = 0;
        chars_seen   = 0;
        values_noted = 0;
    endfunction

    // expand an accepted integer into its decimal text
    function void note_value(logic [63:0] value);
        logic       neg;
        logic [63:0] mag;
        logic [3:0] digits[$];
        t_text_char ch;
        neg = value[63];
        mag = neg ? (~value + 64'd1) : value;
        // least significant digit is found first, so build the list from the front
        do begin
            digits.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 64'd0);
        if (neg) begin
            ch.char_code = CHAR_MINUS;
            ch.is_last   = 1'b0;
            pending_chars.push_back(ch);
        end
        foreach (digits[i]) begin
            ch.char_code = CHAR_ZERO + {4'd0, digits[i]};
            ch.is_last   = (i == digits.size() - 1);
            pending_chars.push_back(ch);
        end
        values_noted++;
    endfunction

    // compare one arrived character with the oldest prediction
    function void check_char(logic [7:0] char_code, logic is_last);
        t_text_char want;
        chars_seen++;
        if (pending_chars.size() == 0) begin
            $error("unexpected character: char_code %h is_last %b", char_code, is_last);
            errors++;
            return;
        end
        want = pending_chars.pop_front();
        if (char_code !== want.char_code) begin
            $error("char_code mismatch: expected %h, actual %h", want.char_code, char_code);
            errors++;
        end
        if (is_last !== want.is_last) begin
            $error("is_last mismatch: expected %b, actual %b", want.is_last, is_last);
            errors++;
        end
    endfunction

    function int owed();
        return pending_chars.size();
    endfunction
endclass

module tb_integer_to_decimal_text_top;

    localparam int HOLD_LEN    = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int RAND_ITEMS  = 160;
    localparam int TAIL_CYCLES = 100;

    logic i_clk;
    logic i_rst_n;
    logic hold_req;
    logic no_idle;
    int   idle_cycles;

    decimal_text_checker text_sb;

    idt_in_if #(.W(64)) in_if ();
    idt_out_if          out_if ();

    integer_to_decimal_text_top #(
        .INT_WIDTH(64),
        .MAX_CHARS(20)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(15, 120);
    endfunction

    // random integer, biased towards short texts, digit boundaries and extremes
    function automatic logic [63:0] pick_value();
        int          r;
        int          w;
        int          k;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (r < 40) begin
            return v;
        end else if (r < 75) begin
            w = $urandom_range(1, 63);
            v = v & ((64'd1 << w) - 64'd1);
        end else if (r < 90) begin
            k = $urandom_range(0, 18);
            v = 64'd1;
            repeat (k) v = v * 64'd10;
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
        end else begin
            case ($urandom_range(0, 4))
                0: v = 64'h8000_0000_0000_0000;
                1: v = 64'h7FFF_FFFF_FFFF_FFFF;
                2: v = 64'd0;
                3: v = 64'd1;
                default: v = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return v;
        end
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    // offer one integer and wait until it is taken
    task automatic send_value(input logic [63:0] v);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // drop valid and wait for every owed character
    task automatic drain();
        in_if.valid <= 1'b0;
        // let the monitor note the request taken at this edge first
        @(posedge i_clk);
        while (text_sb.owed() > 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int stall;
        bit held;
        held = 1'b0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                out_if.ready <= 1'b0;
                held = 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 99) < 25) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // monitor both channels and count cycles without progress
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                text_sb.note_value(in_if.value);
            if (out_if.valid && out_if.ready)
                text_sb.check_char(out_if.char_code, out_if.is_last);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("integer_to_decimal_text_top test failed");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        logic [63:0] directed_vals[$];
        int          fails;
        text_sb      = new();
        i_rst_n     <= 1'b0;
        hold_req    <= 1'b0;
        no_idle     <= 1'b1;
        in_if.valid <= 1'b0;
        in_if.value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, single digits, digit-count boundaries and both signs
        directed_vals = '{
            64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd10, -64'd9, -64'd10,
            64'd99, 64'd100, -64'd100,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
            64'd1000000000000000000, 64'd999999999999999999, -64'd1000000000000000000,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'd4294967296, -64'd4294967295
        };
        foreach (directed_vals[i]) send_value(directed_vals[i]);
        drain();

        // random part with idling on both sides
        no_idle <= 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 50) hold_req <= 1'b1;
            if (n == 90) drain();
            if (n == 140) no_idle <= 1'b1;
            send_value(pick_value());
        end
        drain();

        // let any stray output show itself
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fails = text_sb.errors;
        if (text_sb.owed() != 0) begin
            $error("%0d predicted characters never arrived", text_sb.owed());
            fails++;
        end
        $display("summary: %0d integers converted, %0d characters checked",
                 text_sb.values_noted, text_sb.chars_seen);
        $display("summary: extremes, random widths and signs, long output hold-off, drain pause");
        if (fails == 0)
            $display("integer_to_decimal_text_top test passed");
        else
            $display("integer_to_decimal_text_top test failed");
        $finish;
    end

endmodule

@@ integer_to_decimal_text_top.f @@
rtl/idt_pkg.sv
rtl/idt_if.sv
rtl/idt_dabble_step.sv
rtl/idt_lead_enc.sv
rtl/integer_to_decimal_text_top.sv
bench/tb_integer_to_decimal_text_top.sv
